>>> design/udp_cksum_pkg.sv
package udp_cksum_pkg;

   localparam int unsigned ADDR_SUM_WIDTH = 18;
   localparam logic [15:0] UDP_MIN_LENGTH = 16'd8;
   localparam logic [15:0] UDP_PROTOCOL   = 16'd17;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
   // Bytes below this index are always summed in verify mode, before the
   // length field is fully known.
   localparam logic [15:0] LENGTH_FLOOR   = 16'd6;

   // Byte offsets within the UDP header.
   localparam logic [15:0] IDX_PORT_HI  = 16'd2;
   localparam logic [15:0] IDX_PORT_LO  = 16'd3;
   localparam logic [15:0] IDX_LEN_HI   = 16'd4;
   localparam logic [15:0] IDX_LEN_LO   = 16'd5;
   localparam logic [15:0] IDX_CKSUM_HI = 16'd6;
   localparam logic [15:0] IDX_CKSUM_LO = 16'd7;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_MISMATCH = 2'd2
   } status_type;

   // Everything the finishing stage needs about one completed datagram.
   typedef struct packed {
      logic [31:0]               base_sum;
      logic [ADDR_SUM_WIDTH-1:0] addr_sum;
      logic [15:0]               length;
      logic [15:0]               port;
      logic [15:0]               received_sum;
      logic                      verify;
      logic                      too_short;
   } snap_type;

endpackage

>>> design/udp_cksum_accum.sv
module udp_cksum_accum (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      verify_mode,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_first_byte,
   input  logic                      req_last_byte,
   input  logic [31:0]               req_source_address,
   input  logic [31:0]               req_target_address,
   output logic                      snap_valid,
   input  logic                      snap_ready,
   output udp_cksum_pkg::snap_type   snap
);

   logic [31:0] sum_ff, sum_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] hdr_len_ff, hdr_len_in;
   logic [15:0] rcv_ff, rcv_in;
   logic [15:0] port_ff, port_in;
   logic [udp_cksum_pkg::ADDR_SUM_WIDTH-1:0] addr_sum_ff, addr_sum_in;
   logic        snap_valid_ff, snap_valid_in;
   udp_cksum_pkg::snap_type snap_ff, snap_in;

   logic        accept;
   logic [31:0] cur_sum, nxt_sum;
   logic [15:0] cur_count, nxt_count;
   logic [7:0]  cur_held, nxt_held;
   logic [15:0] cur_hdr_len, nxt_hdr_len;
   logic [15:0] cur_rcv, nxt_rcv;
   logic [15:0] cur_port, nxt_port;
   logic [15:0] limit, final_limit, summed;
   logic [7:0]  sum_byte;
   logic [15:0] final_length;
   logic [31:0] pad;

   assign req_stall  = snap_valid_ff && !snap_ready;
   assign accept     = req_valid && !req_stall;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   always_comb begin
      // A first mark restarts the datagram before this byte is counted.
      cur_sum     = req_first_byte ? 32'd0 : sum_ff;
      cur_count   = req_first_byte ? 16'd0 : count_ff;
      cur_held    = req_first_byte ? 8'd0  : held_ff;
      cur_hdr_len = req_first_byte ? 16'd0 : hdr_len_ff;
      cur_rcv     = req_first_byte ? 16'd0 : rcv_ff;
      cur_port    = req_first_byte ? 16'd0 : port_ff;

      nxt_sum     = cur_sum;
      nxt_count   = cur_count;
      nxt_held    = cur_held;
      nxt_hdr_len = cur_hdr_len;
      nxt_rcv     = cur_rcv;
      nxt_port    = cur_port;

      if (verify_mode) begin
         limit = (cur_hdr_len > udp_cksum_pkg::LENGTH_FLOOR) ?
                 cur_hdr_len : udp_cksum_pkg::LENGTH_FLOOR;
      end else begin
         limit = udp_cksum_pkg::COUNT_MAX;
      end

      sum_byte = req_data_byte;
      if (cur_count == udp_cksum_pkg::IDX_CKSUM_HI ||
          cur_count == udp_cksum_pkg::IDX_CKSUM_LO) begin
         sum_byte = 8'd0;
      end

      if (cur_count != udp_cksum_pkg::COUNT_MAX) begin
         unique case (cur_count)
            udp_cksum_pkg::IDX_PORT_HI:  nxt_port[15:8]    = req_data_byte;
            udp_cksum_pkg::IDX_PORT_LO:  nxt_port[7:0]     = req_data_byte;
            udp_cksum_pkg::IDX_LEN_HI:   nxt_hdr_len[15:8] = req_data_byte;
            udp_cksum_pkg::IDX_LEN_LO:   nxt_hdr_len[7:0]  = req_data_byte;
            udp_cksum_pkg::IDX_CKSUM_HI: nxt_rcv[15:8]     = req_data_byte;
            udp_cksum_pkg::IDX_CKSUM_LO: nxt_rcv[7:0]      = req_data_byte;
            default: ;
         endcase
         if (cur_count < limit) begin
            if (!cur_count[0]) begin
               nxt_held = sum_byte;
            end else begin
               nxt_sum = cur_sum + {16'd0, cur_held, sum_byte};
            end
         end
         nxt_count = cur_count + 16'd1;
      end

      // Close-out values for a last byte.
      if (verify_mode) begin
         final_limit  = (nxt_hdr_len > udp_cksum_pkg::LENGTH_FLOOR) ?
                        nxt_hdr_len : udp_cksum_pkg::LENGTH_FLOOR;
         final_length = nxt_hdr_len;
      end else begin
         final_limit  = udp_cksum_pkg::COUNT_MAX;
         final_length = nxt_count;
      end
      summed = (nxt_count < final_limit) ? nxt_count : final_limit;
      // An odd trailing byte is padded with a zero low byte.
      pad = summed[0] ? {16'd0, nxt_held, 8'd0} : 32'd0;

      addr_sum_in = addr_sum_ff;
      if (accept && req_first_byte) begin
         addr_sum_in = {2'b00, req_source_address[31:16]}
                     + {2'b00, req_source_address[15:0]}
                     + {2'b00, req_target_address[31:16]}
                     + {2'b00, req_target_address[15:0]};
      end

      snap_in.base_sum     = nxt_sum + pad;
      snap_in.addr_sum     = addr_sum_in;
      snap_in.length       = final_length;
      snap_in.port         = nxt_port;
      snap_in.received_sum = nxt_rcv;
      snap_in.verify       = verify_mode;
      snap_in.too_short    = (nxt_count < udp_cksum_pkg::UDP_MIN_LENGTH) ||
                             (verify_mode &&
                              ((nxt_hdr_len < udp_cksum_pkg::UDP_MIN_LENGTH) ||
                               (nxt_count < nxt_hdr_len)));

      sum_in     = sum_ff;
      count_in   = count_ff;
      held_in    = held_ff;
      hdr_len_in = hdr_len_ff;
      rcv_in     = rcv_ff;
      port_in    = port_ff;
      if (accept) begin
         if (req_last_byte) begin
            sum_in     = 32'd0;
            count_in   = 16'd0;
            held_in    = 8'd0;
            hdr_len_in = 16'd0;
            rcv_in     = 16'd0;
            port_in    = 16'd0;
         end else begin
            sum_in     = nxt_sum;
            count_in   = nxt_count;
            held_in    = nxt_held;
            hdr_len_in = nxt_hdr_len;
            rcv_in     = nxt_rcv;
            port_in    = nxt_port;
         end
      end

      snap_valid_in = snap_valid_ff;
      if (accept && req_last_byte) begin
         snap_valid_in = 1'b1;
      end else if (snap_ready) begin
         snap_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         count_ff      <= '0;
         held_ff       <= '0;
         hdr_len_ff    <= '0;
         rcv_ff        <= '0;
         port_ff       <= '0;
         addr_sum_ff   <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         held_ff       <= held_in;
         hdr_len_ff    <= hdr_len_in;
         rcv_ff        <= rcv_in;
         port_ff       <= port_in;
         addr_sum_ff   <= addr_sum_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         snap_ff <= snap_in;
      end
   end

endmodule

>>> design/udp_cksum_final.sv
module udp_cksum_final (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      snap_valid,
   output logic                      snap_ready,
   input  udp_cksum_pkg::snap_type   snap,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [15:0]               rsp_computed_sum,
   output logic [15:0]               rsp_datagram_length,
   output logic [15:0]               rsp_destination_port,
   output logic [1:0]                rsp_status
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] cksum_ff, cksum_in;
   logic [15:0] length_ff;
   logic [15:0] port_ff;
   udp_cksum_pkg::status_type status_ff, status_in;

   logic [31:0] total;
   logic [16:0] fold1;
   logic [16:0] fold2;
   logic        load;

   assign snap_ready = !rsp_valid_ff || !rsp_stall;
   assign load       = snap_valid && snap_ready;

   always_comb begin
      total = snap.base_sum
            + {{(32 - udp_cksum_pkg::ADDR_SUM_WIDTH){1'b0}}, snap.addr_sum}
            + {16'd0, udp_cksum_pkg::UDP_PROTOCOL}
            + {16'd0, snap.length};
      fold1 = {1'b0, total[15:0]} + {1'b0, total[31:16]};
      fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
      cksum_in = ~fold2[15:0];
      // A computed zero is sent as all ones.
      if (cksum_in == 16'd0) begin
         cksum_in = 16'hFFFF;
      end

      if (snap.too_short) begin
         status_in = udp_cksum_pkg::STATUS_SHORT;
      end else if (snap.verify && snap.received_sum != 16'd0 &&
                   snap.received_sum != cksum_in) begin
         status_in = udp_cksum_pkg::STATUS_MISMATCH;
      end else begin
         status_in = udp_cksum_pkg::STATUS_OK;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cksum_ff  <= cksum_in;
         length_ff <= snap.length;
         port_ff   <= snap.port;
         status_ff <= status_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_computed_sum     = cksum_ff;
   assign rsp_datagram_length  = length_ff;
   assign rsp_destination_port = port_ff;
   assign rsp_status           = status_ff;

endmodule

>>> design/udp_checksum_engine.sv
// Takes one byte per cycle while req_stall is low, with no bubbles between beats or datagrams.
// The result of a datagram is registered once its last byte is accepted: the accumulator
// registers a snapshot, then the fold and compare stage registers the result.
// The input stalls only while a finished result is held and the next one is waiting.
// Reset (synchronous, active high) clears the datagram state and the latched
// address sum, empties both stages and sets verify mode.
module udp_checksum_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_target_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_computed_sum,
   output logic [15:0] rsp_datagram_length,
   output logic [15:0] rsp_destination_port,
   output logic [1:0]  rsp_status
);

   logic                    verify_ff;
   logic                    snap_valid;
   logic                    snap_ready;
   udp_cksum_pkg::snap_type snap;

   always_ff @(posedge clock) begin
      if (reset) begin
         verify_ff <= 1'b1;
      end else if (csr_write_enable) begin
         verify_ff <= csr_write_data;
      end
   end

   udp_cksum_accum u_accum (
      .clock              (clock),
      .reset              (reset),
      .verify_mode        (verify_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_last_byte      (req_last_byte),
      .req_source_address (req_source_address),
      .req_target_address (req_target_address),
      .snap_valid         (snap_valid),
      .snap_ready         (snap_ready),
      .snap               (snap)
   );

   udp_cksum_final u_final (
      .clock                (clock),
      .reset                (reset),
      .snap_valid           (snap_valid),
      .snap_ready           (snap_ready),
      .snap                 (snap),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_computed_sum     (rsp_computed_sum),
      .rsp_datagram_length  (rsp_datagram_length),
      .rsp_destination_port (rsp_destination_port),
      .rsp_status           (rsp_status)
   );

endmodule

>>> design/udp_cksum_checker.sv
module udp_cksum_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_computed_sum,
   input logic [15:0] rsp_datagram_length,
   input logic [15:0] rsp_destination_port,
   input logic [1:0]  rsp_status
);

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_computed_sum) &&
         $stable(rsp_datagram_length) && $stable(rsp_destination_port) &&
         $stable(rsp_status))
      else $error("result payload changed while stalled");

   // The checksum is never sent as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_computed_sum != 16'd0)
      else $error("computed checksum is zero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= udp_cksum_pkg::STATUS_MISMATCH)
      else $error("undefined status code");

endmodule

bind udp_checksum_engine udp_cksum_checker u_checker (.*);
